// ----- rtl/tcs_pkg.sv -----
// Shared widths, constants and pipeline bundle types for the circumsphere unit.
package tcs_pkg;

	localparam int CW     = 16;            // input coordinate width
	localparam int DW     = CW + 1;        // edge vector component
	localparam int XW     = 2 * DW + 1;    // cross product component
	localparam int SQW    = 2 * DW + 2;    // squared edge length, signed
	localparam int DPW    = 54;            // triple product and its terms
	localparam int NW     = 72;            // centre numerator
	localparam int GUARD  = 6;             // extra fraction bits of the offset
	localparam int NUMW   = NW + GUARD;    // divider dividend
	localparam int DENW   = DPW + 1;       // divider divisor, 2*|D|
	localparam int REMW   = DENW + 1;      // divider partial remainder
	localparam int QW     = 51;            // quotient bits kept, top one is the clamp
	localparam int OW     = 24;            // output field width
	localparam int MMW    = OW + GUARD;    // offset magnitude that enters the sum of squares
	localparam int SSW    = 2 * MMW + 2;   // sum of three squares
	localparam int SQN    = SSW / 2 + 1;   // square root stages
	localparam int RTW    = 2 * SQN - 1;   // square root working width
	localparam int RW     = 32;            // square root result
	localparam int RNDW   = QW - GUARD + 1;
	localparam int CENW   = RNDW + 2;
	localparam int THRW   = 63;

	localparam logic [THRW-1:0] THR_RESET = 63'd28147497671;

	typedef struct packed {
		logic                 valid;
		logic                 degen;
		logic [2:0]           neg;
		logic [2:0][CW-1:0]   p3;
	} side_t;

	typedef struct packed {
		side_t                side;
		logic [2:0][NUMW-1:0] num;
		logic [DENW-1:0]      den;
	} geo_t;

	typedef struct packed {
		side_t                side;
		logic [2:0][QW-1:0]   quo;
		logic [2:0]           ovf;
	} dres_t;

	typedef struct packed {
		logic                 valid;
		logic                 degen;
		logic                 rsat;
		logic [2:0][OW-1:0]   cen;
	} fin_t;

endpackage

// ----- rtl/tcs_geom.sv -----
// Front end: edge vectors, cross products, triple product, numerators, threshold test.
module tcs_geom (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic [3:0][2:0][tcs_pkg::CW-1:0]         pt,
	input  logic [tcs_pkg::THRW-1:0]                 thr,
	output tcs_pkg::geo_t                            geo
);
	import tcs_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [DW-1:0]  a_s1 [3];
	logic signed [DW-1:0]  b_s1 [3];
	logic signed [DW-1:0]  c_s1 [3];
	logic [2:0][CW-1:0]    p3_s1, p3_s2, p3_s3, p3_s4, p3_s5, p3_s6;

	logic signed [DW-1:0]  a_s2 [3];
	logic signed [XW-1:0]  bc_s2 [3];
	logic signed [XW-1:0]  ca_s2 [3];
	logic signed [XW-1:0]  ab_s2 [3];
	logic signed [SQW-1:0] sq_s2 [3];

	logic signed [DPW-1:0] dp_s3 [3];
	logic signed [NW-1:0]  np_s3 [3][3];

	logic signed [DPW-1:0] d_s4;
	logic signed [NW-1:0]  n_s4 [3];

	logic [DPW-1:0]        absd_s5;
	logic                  dneg_s5;
	logic [NW-1:0]         absn_s5 [3];
	logic [2:0]            nneg_s5;

	logic [63:0]           dsq_s6;
	logic                  small_s6;
	logic [2:0][NUMW-1:0]  num_s6;
	logic [DENW-1:0]       den_s6;
	logic [2:0]            neg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// edge vectors to the fourth point
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			a_s1[k] <= DW'($signed(pt[0][k])) - DW'($signed(pt[3][k]));
			b_s1[k] <= DW'($signed(pt[1][k])) - DW'($signed(pt[3][k]));
			c_s1[k] <= DW'($signed(pt[2][k])) - DW'($signed(pt[3][k]));
		end
		p3_s1 <= pt[3];
	end

	for (genvar k = 0; k < 3; k++) begin : g_cross
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;
		always_ff @(posedge clk) begin
			bc_s2[k] <= XW'(b_s1[K1]) * XW'(c_s1[K2]) - XW'(b_s1[K2]) * XW'(c_s1[K1]);
			ca_s2[k] <= XW'(c_s1[K1]) * XW'(a_s1[K2]) - XW'(c_s1[K2]) * XW'(a_s1[K1]);
			ab_s2[k] <= XW'(a_s1[K1]) * XW'(b_s1[K2]) - XW'(a_s1[K2]) * XW'(b_s1[K1]);
		end
	end

	always_ff @(posedge clk) begin
		sq_s2[0] <= SQW'(a_s1[0]) * SQW'(a_s1[0]) + SQW'(a_s1[1]) * SQW'(a_s1[1])
			+ SQW'(a_s1[2]) * SQW'(a_s1[2]);
		sq_s2[1] <= SQW'(b_s1[0]) * SQW'(b_s1[0]) + SQW'(b_s1[1]) * SQW'(b_s1[1])
			+ SQW'(b_s1[2]) * SQW'(b_s1[2]);
		sq_s2[2] <= SQW'(c_s1[0]) * SQW'(c_s1[0]) + SQW'(c_s1[1]) * SQW'(c_s1[1])
			+ SQW'(c_s1[2]) * SQW'(c_s1[2]);
		a_s2  <= a_s1;
		p3_s2 <= p3_s1;
	end

	// products of the triple product and of the three numerators
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			dp_s3[k]    <= DPW'(a_s2[k]) * DPW'(bc_s2[k]);
			np_s3[k][0] <= NW'(sq_s2[0]) * NW'(bc_s2[k]);
			np_s3[k][1] <= NW'(sq_s2[1]) * NW'(ca_s2[k]);
			np_s3[k][2] <= NW'(sq_s2[2]) * NW'(ab_s2[k]);
		end
		p3_s3 <= p3_s2;
	end

	always_ff @(posedge clk) begin
		d_s4 <= dp_s3[0] + dp_s3[1] + dp_s3[2];
		for (int k = 0; k < 3; k++)
			n_s4[k] <= np_s3[k][0] + np_s3[k][1] + np_s3[k][2];
		p3_s4 <= p3_s3;
	end

	always_ff @(posedge clk) begin
		dneg_s5 <= d_s4[DPW-1];
		absd_s5 <= d_s4[DPW-1] ? DPW'(-d_s4) : DPW'(d_s4);
		for (int k = 0; k < 3; k++) begin
			nneg_s5[k] <= n_s4[k][NW-1];
			absn_s5[k] <= n_s4[k][NW-1] ? NW'(-n_s4[k]) : NW'(n_s4[k]);
		end
		p3_s5 <= p3_s4;
	end

	// square of |D| only matters while |D| fits in 32 bits
	always_ff @(posedge clk) begin
		dsq_s6   <= 64'(absd_s5[31:0]) * 64'(absd_s5[31:0]);
		small_s6 <= ~|absd_s5[DPW-1:32];
		den_s6   <= {absd_s5, 1'b0};
		for (int k = 0; k < 3; k++) begin
			num_s6[k] <= {absn_s5[k], {GUARD{1'b0}}};
			neg_s6[k] <= nneg_s5[k] ^ dneg_s5;
		end
		p3_s6 <= p3_s5;
	end

	always_comb begin
		geo.side.valid = v_s6;
		geo.side.degen = small_s6 && !(dsq_s6 > {1'b0, thr});
		geo.side.neg   = neg_s6;
		geo.side.p3    = p3_s6;
		geo.num        = num_s6;
		geo.den        = den_s6;
	end

endmodule

// ----- rtl/tcs_div.sv -----
// Pipelined restoring divider, three lanes, one quotient bit per stage.
module tcs_div (
	input  logic           clk,
	input  logic           arst_n,
	input  tcs_pkg::geo_t  geo,
	output tcs_pkg::dres_t res
);
	import tcs_pkg::*;

	typedef struct packed {
		side_t                side;
		logic [DENW-1:0]      den;
		logic [2:0][NUMW-1:0] num;
		logic [2:0][REMW-1:0] rem;
		logic [2:0][QW-1:0]   quo;
		logic [2:0]           ovf;
	} div_t;

	div_t st_s [QW+1];

	// seed with the bits above the kept quotient; flag a quotient that needs more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s[0] <= '0;
		end else begin
			st_s[0].side <= geo.side;
			st_s[0].den  <= geo.den;
			st_s[0].num  <= geo.num;
			for (int k = 0; k < 3; k++) begin
				st_s[0].rem[k] <= REMW'(geo.num[k][NUMW-1:QW]);
				st_s[0].quo[k] <= '0;
				st_s[0].ovf[k] <= REMW'(geo.num[k][NUMW-1:QW]) >= REMW'(geo.den);
			end
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_stage
		localparam int BI = QW - j;
		div_t            nxt;
		logic [REMW-1:0] t;

		always_comb begin
			nxt = st_s[j-1];
			t   = '0;
			for (int k = 0; k < 3; k++) begin
				t = {st_s[j-1].rem[k][REMW-2:0], st_s[j-1].num[k][BI]};
				if (t >= REMW'(st_s[j-1].den)) begin
					nxt.rem[k]     = t - REMW'(st_s[j-1].den);
					nxt.quo[k][BI] = 1'b1;
				end else begin
					nxt.rem[k] = t;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				st_s[j] <= '0;
			else
				st_s[j] <= nxt;
		end
	end

	assign res.side = st_s[QW].side;
	assign res.quo  = st_s[QW].quo;
	assign res.ovf  = st_s[QW].ovf;

endmodule

// ----- rtl/tcs_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module tcs_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tcs_pkg::fin_t            in_fin,
	input  logic [tcs_pkg::SSW-1:0]  in_val,
	output tcs_pkg::fin_t            out_fin,
	output logic [tcs_pkg::RW-1:0]   root
);
	import tcs_pkg::*;

	typedef struct packed {
		fin_t            side;
		logic [SSW-1:0]  v;
		logic [RTW-1:0]  r;
	} sq_t;

	sq_t sq_s [SQN];

	for (genvar i = 0; i < SQN; i++) begin : g_stage
		localparam logic [RTW-1:0] BIT = RTW'(1) << (RTW - 1 - 2 * i);
		sq_t            prv;
		sq_t            nxt;
		logic [RTW-1:0] s;

		if (i == 0) begin : g_first
			always_comb begin
				prv.side = in_fin;
				prv.v    = in_val;
				prv.r    = '0;
			end
		end else begin : g_next
			assign prv = sq_s[i-1];
		end

		always_comb begin
			nxt = prv;
			s   = prv.r + BIT;
			if (RTW'(prv.v) >= s) begin
				nxt.v = prv.v - SSW'(s);
				nxt.r = (prv.r >> 1) + BIT;
			end else begin
				nxt.r = prv.r >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_s[i] <= '0;
			else
				sq_s[i] <= nxt;
		end
	end

	assign out_fin = sq_s[SQN-1].side;
	assign root    = sq_s[SQN-1].r[RW-1:0];

endmodule

// ----- rtl/tetrahedron_circumsphere_unit.sv -----
// Top level of the circumsphere unit: ports, threshold register, rounding and output stage.
//
// Fully pipelined circumsphere of four points. A request (twelve signed Q7.8
// coordinates) is taken on any clock edge where start is high; busy never rises,
// so a new point set may enter every cycle. The result shows on the output ports
// for exactly one cycle, marked by done, after the request has passed in order
// the geometry stages (edge vectors, cross products, triple product D,
// numerators, threshold test), the divider that forms each centre offset one
// quotient bit per stage, the rounding and sum-of-squares registers, the square
// root that gives one radius bit per stage, and the output register. The
// receiver cannot hold results off; results come in request order.
// det_threshold (reset 0.0001 in real units) is written through cfg_valid /
// cfg_data, always ready; write it only while no request is in flight. A point
// set whose D*D is not above the threshold returns degenerate with a zero centre
// and radius. Centre components saturate to the signed 24-bit range, the radius to
// the unsigned 24-bit range.
module tetrahedron_circumsphere_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [15:0]            p0_x,
	input  logic signed [15:0]            p0_y,
	input  logic signed [15:0]            p0_z,
	input  logic signed [15:0]            p1_x,
	input  logic signed [15:0]            p1_y,
	input  logic signed [15:0]            p1_z,
	input  logic signed [15:0]            p2_x,
	input  logic signed [15:0]            p2_y,
	input  logic signed [15:0]            p2_z,
	input  logic signed [15:0]            p3_x,
	input  logic signed [15:0]            p3_y,
	input  logic signed [15:0]            p3_z,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcs_pkg::THRW-1:0]      cfg_data,
	output logic                          done,
	output logic signed [23:0]            centre_x,
	output logic signed [23:0]            centre_y,
	output logic signed [23:0]            centre_z,
	output logic [23:0]                   sphere_radius,
	output logic                          degenerate
);
	import tcs_pkg::*;

	localparam logic [QW-1:0] OFF_LIM = QW'(1) << (QW - 1);

	logic [THRW-1:0]         thr_q;
	logic [3:0][2:0][CW-1:0] pts;
	geo_t                    geo;
	dres_t                   dres;

	logic [QW-1:0]           mm_c   [3];
	logic [RNDW-1:0]         rnd_c  [3];
	logic signed [CENW-1:0]  cen_c  [3];
	logic [2:0][OW-1:0]      sat_c;
	logic [2:0]              rsat_c;

	fin_t                    fin_p1, fin_p2, fin_sq;
	logic [2*MMW-1:0]        sq_p1 [3];
	logic [SSW-1:0]          sum_p2;
	logic [RW-1:0]           root;
	logic [RW:0]             rad_c;

	logic                    done_q;
	logic [2:0][OW-1:0]      cen_q;
	logic [OW-1:0]           rad_q;
	logic                    degen_q;

	// never stall: the pipeline advances every cycle
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RESET;
		else if (cfg_valid && cfg_ready)
			thr_q <= cfg_data;
	end

	always_comb begin
		pts[0] = {p0_z, p0_y, p0_x};
		pts[1] = {p1_z, p1_y, p1_x};
		pts[2] = {p2_z, p2_y, p2_x};
		pts[3] = {p3_z, p3_y, p3_x};
	end

	tcs_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.pt       (pts),
		.thr      (thr_q),
		.geo      (geo)
	);

	tcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.geo    (geo),
		.res    (dres)
	);

	// clamp the offset, round it to the nearest LSB (ties away from zero),
	// add it to the fourth point and saturate
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mm_c[k]   = (dres.ovf[k] || dres.quo[k][QW-1]) ? OFF_LIM : dres.quo[k];
			rnd_c[k]  = RNDW'(({1'b0, mm_c[k][QW-1:GUARD-1]} + 1'b1) >> 1);
			cen_c[k]  = dres.side.neg[k]
				? CENW'($signed(dres.side.p3[k])) - $signed({2'b00, rnd_c[k]})
				: CENW'($signed(dres.side.p3[k])) + $signed({2'b00, rnd_c[k]});
			if (&cen_c[k][CENW-1:OW-1] || ~|cen_c[k][CENW-1:OW-1])
				sat_c[k] = cen_c[k][OW-1:0];
			else if (cen_c[k][CENW-1])
				sat_c[k] = {1'b1, {(OW-1){1'b0}}};
			else
				sat_c[k] = {1'b0, {(OW-1){1'b1}}};
			rsat_c[k] = |mm_c[k][QW-1:MMW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_p1 <= '0;
			fin_p2 <= '0;
		end else begin
			fin_p1.valid <= dres.side.valid;
			fin_p1.degen <= dres.side.degen;
			fin_p1.rsat  <= |rsat_c;
			fin_p1.cen   <= sat_c;
			fin_p2       <= fin_p1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			sq_p1[k] <= (2*MMW)'(mm_c[k][MMW-1:0]) * (2*MMW)'(mm_c[k][MMW-1:0]);
		sum_p2 <= SSW'(sq_p1[0]) + SSW'(sq_p1[1]) + SSW'(sq_p1[2]);
	end

	tcs_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fin  (fin_p2),
		.in_val  (sum_p2),
		.out_fin (fin_sq),
		.root    (root)
	);

	assign rad_c = ({1'b0, root} + (RW+1)'(1 << (GUARD - 1))) >> GUARD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= fin_sq.valid;
	end

	// zero everything for a flat point set
	always_ff @(posedge clk) begin
		degen_q <= fin_sq.degen;
		if (fin_sq.degen) begin
			cen_q <= '0;
			rad_q <= '0;
		end else begin
			cen_q <= fin_sq.cen;
			if (fin_sq.rsat || |rad_c[RW:OW])
				rad_q <= {OW{1'b1}};
			else
				rad_q <= rad_c[OW-1:0];
		end
	end

	assign done          = done_q;
	assign centre_x      = $signed(cen_q[0]);
	assign centre_y      = $signed(cen_q[1]);
	assign centre_z      = $signed(cen_q[2]);
	assign sphere_radius = rad_q;
	assign degenerate    = degen_q;

endmodule

// ----- rtl/tcs_checker.sv -----
// Port-level checks of the circumsphere unit and their binding to the top level.
module tcs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [23:0] centre_x,
	input logic signed [23:0] centre_y,
	input logic signed [23:0] centre_z,
	input logic [23:0]        sphere_radius,
	input logic               degenerate
);
	localparam int LATENCY = 93;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> centre_x == 0 && centre_y == 0 && centre_z == 0
			&& sphere_radius == 0)
		else $error("degenerate result with nonzero centre or radius");

	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("request produced no result at the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result without a matching request");

endmodule

bind tetrahedron_circumsphere_unit tcs_checker u_tcs_checker (.*);

// ----- bench/tb_tetrahedron_circumsphere_unit.sv -----
// Self-checking testbench for the pipelined circumsphere unit.
`timescale 1ns / 1ps

module tb_tetrahedron_circumsphere_unit;
	import tcs_pkg::*;

	typedef logic signed [15:0] pset_t [12];

	// One expected sphere, in the port widths of the block.
	typedef struct {
		logic signed [23:0] cx;
		logic signed [23:0] cy;
		logic signed [23:0] cz;
		logic [23:0]        rad;
		logic               degen;
	} sphere_t;

	localparam longint CYCLE_LIMIT = 400000;
	localparam int     DRAIN_WAIT  = 120;    // idle wait that covers the pipeline latency
	localparam int     GUARD_BITS  = 6;
	localparam longint OFF_CLAMP   = 64'd1 << 50;
	localparam longint CEN_MAX     = 8388607;
	localparam longint CEN_MIN     = -8388608;
	localparam logic [63:0] RAD_MAX = 64'hFF_FFFF;
	localparam logic [THRW-1:0] THR_MAX = {THRW{1'b1}};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] p0_x, p0_y, p0_z, p1_x, p1_y, p1_z;
	logic signed [15:0] p2_x, p2_y, p2_z, p3_x, p3_y, p3_z;
	logic cfg_valid;
	logic cfg_ready;
	logic [THRW-1:0] cfg_data;
	logic done;
	logic signed [23:0] centre_x, centre_y, centre_z;
	logic [23:0] sphere_radius;
	logic degenerate;

	// Predictor copy of the threshold register
	logic [THRW-1:0] thr_model;

	sphere_t sphere_q[$];
	int      errors = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      n_degen = 0;
	int      n_sat = 0;
	longint  cycles = 0;

	tetrahedron_circumsphere_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
		.p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
		.p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
		.p3_x(p3_x), .p3_y(p3_y), .p3_z(p3_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .centre_x(centre_x), .centre_y(centre_y), .centre_z(centre_z),
		.sphere_radius(sphere_radius), .degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop if the pipeline hangs or stimulus never drains
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Integer square root, floor, bit-pair method
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Exact circumsphere: offset from p3 is N / (2*D), D the triple product of the edges
	function automatic sphere_t solve_sphere(input pset_t q);
		longint a[3], b[3], c[3], bc[3], ca[3], ab[3];
		longint sqa, sqb, sqc, d, ad, cen, p3v;
		logic signed [127:0] wa, wb, wc, wn;
		logic [127:0] num, den, m;
		logic [63:0] adu, ad2, mm, rnd, sumsq;
		logic rsat;
		sphere_t s;
		int k, k1, k2;
		for (k = 0; k < 3; k++) begin
			a[k] = longint'(q[k]) - longint'(q[9+k]);
			b[k] = longint'(q[3+k]) - longint'(q[9+k]);
			c[k] = longint'(q[6+k]) - longint'(q[9+k]);
		end
		for (k = 0; k < 3; k++) begin
			k1 = (k + 1) % 3;
			k2 = (k + 2) % 3;
			bc[k] = b[k1] * c[k2] - b[k2] * c[k1];
			ca[k] = c[k1] * a[k2] - c[k2] * a[k1];
			ab[k] = a[k1] * b[k2] - a[k2] * b[k1];
		end
		d = a[0] * bc[0] + a[1] * bc[1] + a[2] * bc[2];
		sqa = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		sqb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
		sqc = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
		ad = (d < 0) ? -d : d;
		adu = ad;
		ad2 = adu * adu;
		s.cx = '0; s.cy = '0; s.cz = '0; s.rad = '0; s.degen = 1'b1;
		// Valid only when the Gram determinant D*D clears the threshold
		if (ad < (longint'(1) << 32) && ad2 <= {1'b0, thr_model})
			return s;
		s.degen = 1'b0;
		rsat = 1'b0;
		sumsq = '0;
		den = 128'(adu) << 1;
		for (k = 0; k < 3; k++) begin
			wa = 128'(sqa); wb = 128'(sqb); wc = 128'(sqc);
			wn = wa * 128'(bc[k]) + wb * 128'(ca[k]) + wc * 128'(ab[k]);
			num = (wn < 0) ? -wn : wn;
			num = num << GUARD_BITS;
			m = num / den;
			mm = (m > 128'(OFF_CLAMP)) ? OFF_CLAMP : m[63:0];
			rnd = ((mm >> (GUARD_BITS - 1)) + 1) >> 1;
			p3v = longint'(q[9+k]);
			cen = ((wn < 0) != (d < 0)) ? p3v - longint'(rnd) : p3v + longint'(rnd);
			if (cen > CEN_MAX) cen = CEN_MAX;
			if (cen < CEN_MIN) cen = CEN_MIN;
			case (k)
				0: s.cx = cen[23:0];
				1: s.cy = cen[23:0];
				default: s.cz = cen[23:0];
			endcase
			if (mm >= (64'd1 << (24 + GUARD_BITS))) rsat = 1'b1;
			else sumsq = sumsq + mm * mm;
		end
		if (rsat) begin
			s.rad = RAD_MAX[23:0];
		end else begin
			ad2 = (isqrt64(sumsq) + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
			s.rad = (ad2 > RAD_MAX) ? RAD_MAX[23:0] : ad2[23:0];
		end
		return s;
	endfunction

	// Offer one point set; hold it until the block takes it, then log the expected sphere.
	// Leaves start high so a following request can go back to back.
	task automatic send_request(input pset_t q);
		@(negedge clk);
		{p0_x, p0_y, p0_z} = {q[0], q[1], q[2]};
		{p1_x, p1_y, p1_z} = {q[3], q[4], q[5]};
		{p2_x, p2_y, p2_z} = {q[6], q[7], q[8]};
		{p3_x, p3_y, p3_z} = {q[9], q[10], q[11]};
		start = 1'b1;
		while (busy) @(negedge clk);
		@(posedge clk);
		sphere_q.push_back(solve_sphere(q));
		n_sent++;
	endtask

	// Drop start and idle for as long as n asks
	task automatic idle_cycles(input int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n > 0 ? n - 1 : 0) @(negedge clk);
	endtask

	// Drain the pipeline, then write the threshold register
	task automatic write_threshold(input logic [THRW-1:0] value);
		idle_cycles(1);
		wait (sphere_q.size() == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		thr_model = value;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = THRW'($urandom);
	endtask

	function automatic pset_t pts(input int ax, ay, az, bx, by, bz,
			input int cx, cy, cz, dx, dy, dz);
		pset_t q;
		q = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
			16'(cx), 16'(cy), 16'(cz), 16'(dx), 16'(dy), 16'(dz)};
		return q;
	endfunction

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return 16'(v);
	endfunction

	// Well-formed tetrahedron: four points scattered around a random centre
	function automatic pset_t random_cluster();
		pset_t q;
		int ctr[3], spread, i;
		spread = 1 << $urandom_range(1, 15);
		for (i = 0; i < 3; i++) ctr[i] = $urandom_range(0, 65535) - 32768;
		for (i = 0; i < 12; i++)
			q[i] = clamp16(ctr[i % 3] + int'($urandom_range(0, 2 * spread)) - spread);
		return q;
	endfunction

	// Nearly flat set: p2 close to the plane of the others, for tiny D and huge centres
	function automatic pset_t random_flat();
		pset_t q;
		int i;
		q = random_cluster();
		for (i = 0; i < 3; i++)
			q[6+i] = clamp16(int'(q[i]) + int'(q[3+i]) - int'(q[9+i])
				+ int'($urandom_range(0, 2)) - 1);
		return q;
	endfunction

	// Fully random coordinates, every bit free
	function automatic pset_t random_noise();
		pset_t q;
		int i;
		for (i = 0; i < 12; i++) q[i] = 16'($urandom);
		return q;
	endfunction

	// Compare each sphere on the ports with the oldest expected one
	always @(posedge clk) begin
		sphere_t e;
		if (arst_n && done) begin
			if (sphere_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got centre %0d %0d %0d r %0d d %0b",
					$time, centre_x, centre_y, centre_z, sphere_radius, degenerate);
				errors++;
			end else begin
				e = sphere_q.pop_front();
				n_checked++;
				if (e.degen) n_degen++;
				if (!e.degen && e.rad == RAD_MAX[23:0]) n_sat++;
				if (centre_x !== e.cx) begin
					$display("%0t: centre_x expected %0d actual %0d", $time, e.cx, centre_x);
					errors++;
				end
				if (centre_y !== e.cy) begin
					$display("%0t: centre_y expected %0d actual %0d", $time, e.cy, centre_y);
					errors++;
				end
				if (centre_z !== e.cz) begin
					$display("%0t: centre_z expected %0d actual %0d", $time, e.cz, centre_z);
					errors++;
				end
				if (sphere_radius !== e.rad) begin
					$display("%0t: sphere_radius expected %0d actual %0d",
						$time, e.rad, sphere_radius);
					errors++;
				end
				if (degenerate !== e.degen) begin
					$display("%0t: degenerate expected %0b actual %0b",
						$time, e.degen, degenerate);
					errors++;
				end
			end
		end
	end

	// Reset threshold: tetrahedra below, just above and well above 0.0001 in real units
	task automatic test_reset_threshold();
		send_request(pts(4, 0, 0, 0, 41943, 0, 0, 0, 1, 0, 0, 0));
		send_request(pts(17, 0, 0, 0, 9869, 0, 0, 0, 1, 0, 0, 0));
		send_request(pts(256, 0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0));
		idle_cycles(3);
	endtask

	// Field extremes, coincident points and saturating centres
	task automatic test_directed();
		write_threshold('0);
		send_request(pts(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(pts(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0));
		send_request(pts(32767, -32768, -32768, -32768, 32767, -32768,
			-32768, -32768, 32767, -32768, -32768, -32768));
		send_request(pts(-32768, 32767, 32767, 32767, -32768, 32767,
			32767, 32767, -32768, 32767, 32767, 32767));
		send_request(pts(32767, 32767, 32767, -32768, -32768, -32768,
			32767, -32768, 0, -32768, 32767, 0));
		// nearly flat: centre far outside the output range
		send_request(pts(-32768, -32768, 0, 32767, -32768, 0,
			0, 32767, 1, 0, 0, 0));
		send_request(pts(-32768, 0, 0, 32767, 0, 0, 0, 1, 0, 0, 0, 1));
		// two coincident points
		send_request(pts(100, 200, 300, 100, 200, 300, 5, 6, 7, -8, 9, -10));
		send_request(pts(256, 512, -256, -512, 256, 0, 0, -256, 512, 128, 128, 128));
		idle_cycles(2);
		write_threshold(THR_MAX);
		send_request(pts(32767, -32768, -32768, -32768, 32767, -32768,
			-32768, -32768, 32767, -32768, -32768, -32768));
		send_request(pts(1000, 0, 0, 0, 1000, 0, 0, 0, 1000, 0, 0, 0));
		idle_cycles(2);
	endtask

	// Threshold compare is strict: D*D equal to the register is degenerate
	task automatic test_threshold_edge();
		write_threshold(63'd1000000000000000000);
		send_request(pts(1000, 0, 0, 0, 1000, 0, 0, 0, 1000, 0, 0, 0));
		write_threshold(63'd999999999999999999);
		send_request(pts(1000, 0, 0, 0, 1000, 0, 0, 0, 1000, 0, 0, 0));
		write_threshold(63'd1);
		send_request(pts(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0));
		send_request(pts(1, 0, 0, 0, 2, 0, 0, 0, 1, 0, 0, 0));
		idle_cycles(2);
	endtask

	// Random point sets in bursts, under several threshold settings
	task automatic test_random(input int count);
		pset_t q;
		int sent, burst, sel, phase;
		logic [THRW-1:0] thr;
		sent = 0;
		phase = 0;
		while (sent < count) begin
			if (sent >= phase * (count / 5)) begin
				case (phase % 5)
					0: thr = THR_RESET;
					1: thr = '0;
					2: thr = THRW'({$urandom, $urandom} >> $urandom_range(1, 40));
					3: thr = THR_MAX;
					default: thr = 63'd1 << $urandom_range(20, 62);
				endcase
				write_threshold(thr);
				phase++;
			end
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				sel = $urandom_range(0, 9);
				if (sel < 6) q = random_cluster();
				else if (sel < 8) q = random_flat();
				else q = random_noise();
				send_request(q);
				sent++;
			end
			// some bursts run straight into the next one
			if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 9));
		end
		idle_cycles(1);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z} = '0;
		{p2_x, p2_y, p2_z, p3_x, p3_y, p3_z} = '0;
		thr_model = THR_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_threshold();
		test_directed();
		test_threshold_edge();
		test_random(525);

		wait (sphere_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d point sets, checked %0d spheres (%0d degenerate, %0d radius clamped).",
			n_sent, n_checked, n_degen, n_sat);
		$display("Threshold went through reset, zero, maximum, exact-edge and random values.");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
